/* sv/framebuffer_line_rect_drawer_defines.svh */
// Assertion macros shared by the frame store drawer RTL.
`ifndef FRAMEBUFFER_LINE_RECT_DRAWER_DEFINES_SVH
`define FRAMEBUFFER_LINE_RECT_DRAWER_DEFINES_SVH

`ifndef SYNTHESIS

// Same-cycle implication: when ante holds, cons holds in that cycle.
`define FLRD_ASSERT_IMPL(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication: when ante holds, cons holds in the next cycle.
`define FLRD_ASSERT_NEXT(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`else

`define FLRD_ASSERT_IMPL(name, clk, rst, ante, cons, msg)

`define FLRD_ASSERT_NEXT(name, clk, rst, ante, cons, msg)

`endif

`endif

/* sv/flrd_pkg.sv */
// Shared types and constants for the frame store drawer.
`timescale 1ns / 1ps
`default_nettype none

package flrd_pkg;

   typedef enum logic [2:0] {
      KIND_LINE  = 3'd0,
      KIND_RECT  = 3'd1,
      KIND_CLEAR = 3'd2,
      KIND_FILL  = 3'd3,
      KIND_READ  = 3'd4
   } kind_type;

   typedef enum logic [1:0] {
      COLOR_SET    = 2'd0,
      COLOR_CLEAR  = 2'd1,
      COLOR_INVERT = 2'd2
   } color_type;

   localparam logic [7:0] BYTE_ONES  = 8'hFF;
   localparam logic [7:0] BYTE_ZEROS = 8'h00;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load;
      logic line_s1;
      logic line_s2;
      logic line_s3;
      logic rect_setup;
      logic advance;
      logic mem_rd_pix;
      logic mem_wr_pix;
      logic mem_rd_byte;
      logic sweep_wr;
      logic sweep_ones;
      logic rsp_load;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic pix_on;
      logic iter_last;
      logic rect_empty;
      logic sweep_last;
   } status_type;

endpackage

`default_nettype wire

/* sv/flrd_datapath.sv */
// Datapath: frame store memory, line and rectangle iterator, pixel update, response data.
`timescale 1ns / 1ps
`default_nettype none
`include "framebuffer_line_rect_drawer_defines.svh"

module flrd_datapath #(
   parameter int PANEL_COLS = 128,
   parameter int PANEL_ROWS = 32
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_wr_en,
   input  logic [1:0]           csr_wr_data,
   input  logic [2:0]           req_kind,
   input  logic [7:0]           req_x_start,
   input  logic [7:0]           req_y_start,
   input  logic [7:0]           req_x_end,
   input  logic [7:0]           req_y_end,
   input  logic [7:0]           req_rect_width,
   input  logic [7:0]           req_rect_height,
   input  logic [8:0]           req_byte_index,
   input  flrd_pkg::cmd_type    cmd,
   output flrd_pkg::status_type status,
   output logic [7:0]           rsp_read_data
);
   import flrd_pkg::*;

   localparam int STORE_BYTES = (PANEL_COLS * PANEL_ROWS) / 8;
   localparam int ADDR_W      = $clog2(STORE_BYTES);
   localparam int FULL_W      = $clog2(PANEL_COLS * ((PANEL_ROWS + 7) / 8)) + 1;
   localparam int LAST_ADDR   = STORE_BYTES - 1;

   logic [1:0]          color_ff;
   logic [2:0]          kind_ff;
   logic [7:0]          xs_ff, ys_ff, xe_ff, ye_ff, w_ff, h_ff;
   logic [8:0]          idx_ff;

   logic [7:0]          cur_a_ff, cur_b_ff, end_a_ff, end_b_ff, start_b_ff;
   logic                steep_ff, step_neg_ff;
   logic [7:0]          dx_ff, dy_ff;
   logic signed [9:0]   err_ff;

   logic [ADDR_W-1:0]   sweep_cnt_ff;
   logic [7:0]          store_mem [STORE_BYTES];
   logic [7:0]          rd_data_ff;
   logic [7:0]          rsp_data_ff;

   logic [7:0]          abs_dx, abs_dy, dx_line, dy_line;
   logic                s1_steep, is_rect;
   logic signed [9:0]   err_sub, err_next;
   logic [7:0]          cur_b_step;
   logic [9:0]          col_sum, row_sum, col_clip, row_clip, col_clip_m1, row_clip_m1;
   logic [7:0]          pix_col, pix_row, pix_bit, pix_new;
   logic [FULL_W-1:0]   pix_addr_full;
   logic [ADDR_W-1:0]   pix_addr, byte_addr;
   logic                byte_ok;
   logic                mem_we, mem_re;
   logic [ADDR_W-1:0]   mem_waddr, mem_raddr;
   logic [7:0]          mem_wdata;

   // Line setup terms
   always_comb begin
      abs_dx   = (xe_ff >= xs_ff) ? (xe_ff - xs_ff) : (xs_ff - xe_ff);
      abs_dy   = (ye_ff >= ys_ff) ? (ye_ff - ys_ff) : (ys_ff - ye_ff);
      s1_steep = abs_dy > abs_dx;
      dx_line  = end_a_ff - cur_a_ff;
      dy_line  = (end_b_ff >= cur_b_ff) ? (end_b_ff - cur_b_ff) : (cur_b_ff - end_b_ff);
   end

   // Bresenham error step
   always_comb begin
      err_sub    = err_ff - $signed({2'b00, dy_ff});
      err_next   = err_sub[9] ? (err_sub + $signed({2'b00, dx_ff})) : err_sub;
      cur_b_step = step_neg_ff ? (cur_b_ff - 8'd1) : (cur_b_ff + 8'd1);
   end

   // Rectangle clipped to the screen edge
   always_comb begin
      col_sum     = {2'b00, xs_ff} + {2'b00, w_ff};
      row_sum     = {2'b00, ys_ff} + {2'b00, h_ff};
      col_clip    = (col_sum > 10'(PANEL_COLS)) ? 10'(PANEL_COLS) : col_sum;
      row_clip    = (row_sum > 10'(PANEL_ROWS)) ? 10'(PANEL_ROWS) : row_sum;
      col_clip_m1 = col_clip - 10'd1;
      row_clip_m1 = row_clip - 10'd1;
   end

   // Current pixel, its byte address and the modified byte
   always_comb begin
      is_rect       = kind_ff == KIND_RECT;
      pix_col       = steep_ff ? cur_b_ff : cur_a_ff;
      pix_row       = steep_ff ? cur_a_ff : cur_b_ff;
      pix_addr_full = FULL_W'(pix_col) + FULL_W'(pix_row[7:3]) * FULL_W'(PANEL_COLS);
      pix_addr      = pix_addr_full[ADDR_W-1:0];
      pix_bit       = 8'd1 << pix_row[2:0];
      unique case (color_type'(color_ff))
         COLOR_SET:    pix_new = rd_data_ff | pix_bit;
         COLOR_CLEAR:  pix_new = rd_data_ff & ~pix_bit;
         COLOR_INVERT: pix_new = rd_data_ff ^ pix_bit;
         default:      pix_new = rd_data_ff;
      endcase
      byte_ok   = int'(idx_ff) < STORE_BYTES;
      byte_addr = ADDR_W'(idx_ff);
   end

   always_comb begin
      status.pix_on     = (int'(pix_col) < PANEL_COLS) && (int'(pix_row) < PANEL_ROWS)
                          && (pix_addr_full < FULL_W'(STORE_BYTES));
      status.iter_last  = (cur_a_ff == end_a_ff) && (!is_rect || (cur_b_ff == end_b_ff));
      status.rect_empty = (w_ff == 8'd0) || (h_ff == 8'd0) ||
                          (int'(xs_ff) >= PANEL_COLS) || (int'(ys_ff) >= PANEL_ROWS);
      status.sweep_last = sweep_cnt_ff == ADDR_W'(LAST_ADDR);
   end

   always_comb begin
      mem_we    = cmd.mem_wr_pix || cmd.sweep_wr;
      mem_re    = cmd.mem_rd_pix || cmd.mem_rd_byte;
      mem_waddr = cmd.sweep_wr ? sweep_cnt_ff : pix_addr;
      mem_wdata = cmd.sweep_wr ? (cmd.sweep_ones ? BYTE_ONES : BYTE_ZEROS) : pix_new;
      mem_raddr = cmd.mem_rd_byte ? byte_addr : pix_addr;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         store_mem[mem_waddr] <= mem_wdata;
      end
      if (mem_re) begin
         rd_data_ff <= store_mem[mem_raddr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         color_ff     <= 2'd0;
         sweep_cnt_ff <= '0;
      end else begin
         if (csr_wr_en) begin
            color_ff <= csr_wr_data;
         end
         if (cmd.sweep_wr) begin
            sweep_cnt_ff <= status.sweep_last ? '0 : sweep_cnt_ff + ADDR_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         kind_ff <= req_kind;
         xs_ff   <= req_x_start;
         ys_ff   <= req_y_start;
         xe_ff   <= req_x_end;
         ye_ff   <= req_y_end;
         w_ff    <= req_rect_width;
         h_ff    <= req_rect_height;
         idx_ff  <= req_byte_index;
      end
      if (cmd.rsp_load) begin
         rsp_data_ff <= ((kind_ff == KIND_READ) && byte_ok) ? rd_data_ff : BYTE_ZEROS;
      end
   end

   // Iterator: line setup in three steps or a rectangle setup, then one advance per pixel
   always_ff @(posedge clock) begin
      priority if (cmd.line_s1) begin
         steep_ff <= s1_steep;
         if (s1_steep) begin
            cur_a_ff <= ys_ff;
            cur_b_ff <= xs_ff;
            end_a_ff <= ye_ff;
            end_b_ff <= xe_ff;
         end else begin
            cur_a_ff <= xs_ff;
            cur_b_ff <= ys_ff;
            end_a_ff <= xe_ff;
            end_b_ff <= ye_ff;
         end
      end else if (cmd.line_s2) begin
         if (cur_a_ff > end_a_ff) begin
            cur_a_ff <= end_a_ff;
            end_a_ff <= cur_a_ff;
            cur_b_ff <= end_b_ff;
            end_b_ff <= cur_b_ff;
         end
      end else if (cmd.line_s3) begin
         dx_ff       <= dx_line;
         dy_ff       <= dy_line;
         err_ff      <= $signed({3'b000, dx_line[7:1]});
         step_neg_ff <= !(cur_b_ff < end_b_ff);
      end else if (cmd.rect_setup) begin
         steep_ff   <= 1'b0;
         cur_a_ff   <= xs_ff;
         cur_b_ff   <= ys_ff;
         start_b_ff <= ys_ff;
         end_a_ff   <= col_clip_m1[7:0];
         end_b_ff   <= row_clip_m1[7:0];
      end else if (cmd.advance) begin
         if (is_rect) begin
            if (cur_b_ff == end_b_ff) begin
               cur_a_ff <= cur_a_ff + 8'd1;
               cur_b_ff <= start_b_ff;
            end else begin
               cur_b_ff <= cur_b_ff + 8'd1;
            end
         end else begin
            cur_a_ff <= cur_a_ff + 8'd1;
            err_ff   <= err_next;
            if (err_sub[9]) begin
               cur_b_ff <= cur_b_step;
            end
         end
      end
   end

   assign rsp_read_data = rsp_data_ff;

   `FLRD_ASSERT_IMPL(a_pix_write_after_read, clock, reset, cmd.mem_wr_pix,
      $past(cmd.mem_rd_pix) && $stable(pix_addr), "pixel write without matching read")
   `FLRD_ASSERT_IMPL(a_pix_write_on_screen, clock, reset, cmd.mem_wr_pix,
      status.pix_on, "pixel write off the screen")
   `FLRD_ASSERT_NEXT(a_line_major_steps, clock, reset,
      cmd.advance && !is_rect && !status.iter_last,
      cur_a_ff == $past(cur_a_ff) + 8'd1, "line major axis did not step by one")

endmodule

`default_nettype wire

/* sv/flrd_ctrl.sv */
// Controller state machine: sequences setup, pixel read-modify-write, sweeps and the response.
`timescale 1ns / 1ps
`default_nettype none
`include "framebuffer_line_rect_drawer_defines.svh"

module flrd_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic [2:0]           req_kind,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output flrd_pkg::cmd_type    cmd,
   input  flrd_pkg::status_type status
);
   import flrd_pkg::*;

   typedef enum logic [3:0] {
      ST_INIT_CLEAR,
      ST_IDLE,
      ST_LINE_S1,
      ST_LINE_S2,
      ST_LINE_S3,
      ST_RECT_SETUP,
      ST_SWEEP_ZERO,
      ST_SWEEP_ONES,
      ST_READ_MEM,
      ST_PIX_RD,
      ST_PIX_WR,
      ST_DONE
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff;
   logic      accept, rsp_free;

   assign req_ready = state_ff == ST_IDLE;
   assign accept    = req_valid && req_ready;
   assign rsp_free  = !rsp_valid_ff || rsp_ready;
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      unique case (state_ff)
         ST_INIT_CLEAR: begin
            cmd.sweep_wr = 1'b1;
            if (status.sweep_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (accept) begin
               cmd.load = 1'b1;
               unique case (kind_type'(req_kind))
                  KIND_LINE:  state_in = ST_LINE_S1;
                  KIND_RECT:  state_in = ST_RECT_SETUP;
                  KIND_CLEAR: state_in = ST_SWEEP_ZERO;
                  KIND_FILL:  state_in = ST_SWEEP_ONES;
                  KIND_READ:  state_in = ST_READ_MEM;
                  default:    state_in = ST_DONE;
               endcase
            end
         end
         ST_LINE_S1: begin
            cmd.line_s1 = 1'b1;
            state_in    = ST_LINE_S2;
         end
         ST_LINE_S2: begin
            cmd.line_s2 = 1'b1;
            state_in    = ST_LINE_S3;
         end
         ST_LINE_S3: begin
            cmd.line_s3 = 1'b1;
            state_in    = ST_PIX_RD;
         end
         ST_RECT_SETUP: begin
            cmd.rect_setup = 1'b1;
            state_in       = status.rect_empty ? ST_DONE : ST_PIX_RD;
         end
         ST_SWEEP_ZERO: begin
            cmd.sweep_wr = 1'b1;
            if (status.sweep_last) begin
               state_in = ST_DONE;
            end
         end
         ST_SWEEP_ONES: begin
            cmd.sweep_wr   = 1'b1;
            cmd.sweep_ones = 1'b1;
            if (status.sweep_last) begin
               state_in = ST_DONE;
            end
         end
         ST_READ_MEM: begin
            cmd.mem_rd_byte = 1'b1;
            state_in        = ST_DONE;
         end
         ST_PIX_RD: begin
            if (status.pix_on) begin
               cmd.mem_rd_pix = 1'b1;
               state_in       = ST_PIX_WR;
            end else begin
               cmd.advance = 1'b1;
               if (status.iter_last) begin
                  state_in = ST_DONE;
               end
            end
         end
         ST_PIX_WR: begin
            cmd.mem_wr_pix = 1'b1;
            cmd.advance    = 1'b1;
            state_in       = status.iter_last ? ST_DONE : ST_PIX_RD;
         end
         ST_DONE: begin
            if (rsp_free) begin
               cmd.rsp_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_INIT_CLEAR;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= cmd.rsp_load || (rsp_valid_ff && !rsp_ready);
      end
   end

   `FLRD_ASSERT_IMPL(a_rsp_slot_free, clock, reset, cmd.rsp_load, !rsp_valid_ff || rsp_ready, "response overwrites an untaken beat")
   `FLRD_ASSERT_NEXT(a_accept_leaves_idle, clock, reset, req_valid && req_ready, state_ff != ST_IDLE, "accepted beat did not start work")
   `FLRD_ASSERT_IMPL(a_sweep_exclusive, clock, reset, cmd.sweep_wr, !cmd.mem_wr_pix && !cmd.mem_rd_pix && !cmd.mem_rd_byte, "sweep collides with pixel access")

endmodule

`default_nettype wire

/* sv/framebuffer_line_rect_drawer.sv */
// Top level of the page-packed monochrome frame store drawer.
`timescale 1ns / 1ps
`default_nettype none

// Usage:
//   Commands arrive on the req_ channel (valid/ready); each accepted beat
//   yields exactly one beat on the rsp_ channel carrying rsp_read_data
//   (the addressed store byte for an in-range byte read, zero otherwise).
//   csr_wr_en/csr_wr_data set the pixel mode; write it only while idle.
// Command sequencing (one command in flight at a time; the single memory port does
//   each pixel read-modify-write as a read step followed by a write step):
//   line: setup states LINE_S1, LINE_S2, LINE_S3, then a read and a write per
//   on-screen pixel and only an advance per off-screen pixel
//   rectangle: setup, then a read and a write per on-screen pixel (clipped)
//   clear/fill store: one byte a cycle; byte read: one read; unused kinds: none.
// Reset: the store is zeroed by a pass over its PANEL_COLS*PANEL_ROWS/8 bytes
//   (512 at default size) with req_ready low; pixel mode resets to set.
// Stall: a finished result waits in the output register; the next command is
//   still accepted and runs, and only its completion waits for the slot.
module framebuffer_line_rect_drawer #(
   parameter int PANEL_COLS = 128,
   parameter int PANEL_ROWS = 32
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [2:0] req_kind,
   input  logic [7:0] req_x_start,
   input  logic [7:0] req_y_start,
   input  logic [7:0] req_x_end,
   input  logic [7:0] req_y_end,
   input  logic [7:0] req_rect_width,
   input  logic [7:0] req_rect_height,
   input  logic [8:0] req_byte_index,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [7:0] rsp_read_data,
   input  logic       csr_wr_en,
   input  logic [1:0] csr_wr_data
);
   import flrd_pkg::*;

   cmd_type    cmd;
   status_type status;

   // Sequence each command: setup, pixel steps, sweeps, response hand-off
   flrd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_kind  (req_kind),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd),
      .status    (status)
   );

   // Hold the store, the iterator and the response byte
   flrd_datapath #(
      .PANEL_COLS (PANEL_COLS),
      .PANEL_ROWS (PANEL_ROWS)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .csr_wr_en       (csr_wr_en),
      .csr_wr_data     (csr_wr_data),
      .req_kind        (req_kind),
      .req_x_start     (req_x_start),
      .req_y_start     (req_y_start),
      .req_x_end       (req_x_end),
      .req_y_end       (req_y_end),
      .req_rect_width  (req_rect_width),
      .req_rect_height (req_rect_height),
      .req_byte_index  (req_byte_index),
      .cmd             (cmd),
      .status          (status),
      .rsp_read_data   (rsp_read_data)
   );

endmodule

`default_nettype wire
